// ----- src/mevs_pkg.sv -----
// Package for the MIDI event byte serializer: event and frame types and
// the constants of the variable-length quantity encoding. No dependencies.
`timescale 1ns / 1ps

package mevs_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned MaxBytes   = 8;
   localparam int unsigned MaxGroups  = 5;
   localparam int unsigned GroupWidth = 7;
   localparam int unsigned CountWidth = $clog2(MaxBytes + 1);
   localparam int unsigned ReqWidth   = 64;

   localparam logic [GroupWidth-1:0] VlqMask = 7'd127;
   localparam logic [ByteWidth-1:0]  VlqCont = 8'd128;

   typedef struct packed {
      logic [31:0]          delta_time;
      logic [ByteWidth-1:0] status_byte;
      logic [1:0]           data_count;
      logic [ByteWidth-1:0] data_first;
      logic [ByteWidth-1:0] data_second;
   } event_type;

   typedef struct packed {
      logic [MaxBytes-1:0][ByteWidth-1:0] bytes;
      logic [CountWidth-1:0]              count;
   } frame_type;

endpackage

// ----- src/mevs_encode.sv -----
// Event encoder: splits the delta time into 7-bit groups and lays out all
// bytes of one event in order, with the byte count. Uses mevs_pkg.
`timescale 1ns / 1ps

module mevs_encode
   import mevs_pkg::*;
(
   input  event_type event_in,
   output frame_type frame_out
);

   logic [MaxGroups-1:0][GroupWidth-1:0] groups;
   logic [2:0] num_groups;
   logic [1:0] data_num;

   assign groups[0] = event_in.delta_time[6:0] & VlqMask;
   assign groups[1] = event_in.delta_time[13:7];
   assign groups[2] = event_in.delta_time[20:14];
   assign groups[3] = event_in.delta_time[27:21];
   assign groups[4] = {3'b000, event_in.delta_time[31:28]};

   always_comb begin
      priority if (event_in.delta_time[31:28] != 4'd0) begin
         num_groups = 3'd5;
      end else if (event_in.delta_time[27:21] != 7'd0) begin
         num_groups = 3'd4;
      end else if (event_in.delta_time[20:14] != 7'd0) begin
         num_groups = 3'd3;
      end else if (event_in.delta_time[13:7] != 7'd0) begin
         num_groups = 3'd2;
      end else begin
         num_groups = 3'd1;
      end
   end

   assign data_num = (event_in.data_count == 2'd3) ? 2'd2 : event_in.data_count;

   always_comb begin
      logic [2:0] pos;
      logic [2:0] gidx;
      logic       cont;
      for (int p = 0; p < MaxBytes; p++) begin
         pos  = 3'(p);
         gidx = num_groups - pos - 3'd1;
         cont = (pos != num_groups - 3'd1);
         if (pos < num_groups) begin
            frame_out.bytes[p] = {1'b0, groups[gidx]} | (cont ? VlqCont : '0);
         end else if (pos == num_groups) begin
            frame_out.bytes[p] = event_in.status_byte;
         end else if (pos == num_groups + 3'd1) begin
            frame_out.bytes[p] = event_in.data_first;
         end else begin
            frame_out.bytes[p] = event_in.data_second;
         end
      end
      frame_out.count = CountWidth'(num_groups) + CountWidth'(1) + CountWidth'(data_num);
   end

endmodule

// ----- src/mevs_serial.sv -----
// Output stage: holds one encoded event and shifts its bytes onto the
// response stream, one per handshake. Uses mevs_pkg.
`timescale 1ns / 1ps

module mevs_serial
   import mevs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  frame_type            frame_in,
   output logic                 free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [ByteWidth-1:0] rsp_tdata,   // out_byte[7:0]
   output logic                 rsp_tlast
);

   logic                               valid_ff, valid_in;
   logic [CountWidth-1:0]              remain_ff, remain_in;
   logic [MaxBytes-1:0][ByteWidth-1:0] bytes_ff, bytes_in;
   logic                               take;
   logic                               final_byte;

   assign final_byte = (remain_ff == CountWidth'(1));
   assign take       = valid_ff & rsp_tready;
   assign free       = ~valid_ff | (take & final_byte);

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = bytes_ff[0];
   assign rsp_tlast  = final_byte;

   always_comb begin
      valid_in  = valid_ff;
      remain_in = remain_ff;
      bytes_in  = bytes_ff;
      if (load) begin
         valid_in  = 1'b1;
         remain_in = frame_in.count;
         bytes_in  = frame_in.bytes;
      end else if (take) begin
         valid_in  = ~final_byte;
         remain_in = remain_ff - CountWidth'(1);
         for (int i = 0; i < MaxBytes - 1; i++) begin
            bytes_in[i] = bytes_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         remain_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

endmodule

// ----- src/midi_event_byte_serializer_core.sv -----
// MIDI event byte serializer: an event request is held in an input register,
// encoded into its byte sequence and streamed out one byte per cycle while
// the receiver is ready. A request passes the input register, then the output
// register, before its first byte appears. An event is 2 to 8 bytes long, set
// by its byte count, and the next request is taken while one streams out.
// Reset (synchronous, active high) empties the input and output registers.
`timescale 1ns / 1ps

module midi_event_byte_serializer_core
   import mevs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // delta_time[31:0], status_byte[39:32], data_count[41:40],
   // data_first[49:42], data_second[57:50], zero fill[63:58]
   input  logic [ReqWidth-1:0]  req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [ByteWidth-1:0] rsp_tdata,   // out_byte[7:0]
   output logic                 rsp_tlast
);

   event_type ev_ff, ev_in;
   logic      ev_valid_ff, ev_valid_in;
   logic      load;
   logic      free;
   logic      accept;
   frame_type frame;

   assign load       = ev_valid_ff & free;
   assign req_tready = ~ev_valid_ff | load;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      ev_in             = ev_ff;
      ev_valid_in       = ev_valid_ff & ~load;
      if (accept) begin
         ev_in.delta_time  = req_tdata[31:0];
         ev_in.status_byte = req_tdata[39:32];
         ev_in.data_count  = req_tdata[41:40];
         ev_in.data_first  = req_tdata[49:42];
         ev_in.data_second = req_tdata[57:50];
         ev_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff <= ev_in;
   end

   mevs_encode u_encode (
      .event_in  (ev_ff),
      .frame_out (frame)
   );

   mevs_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .frame_in   (frame),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- test/midi_event_byte_serializer_core_tb.sv -----
// Self-checking testbench for midi_event_byte_serializer_core: directed and random track
// events are streamed in, and every output byte is checked against a predicted byte sequence.
// Depends on mevs_pkg and the serializer core RTL.
`timescale 1ns / 1ps

module midi_event_byte_serializer_core_tb;
   import mevs_pkg::*;

   typedef struct {
      logic [ByteWidth-1:0] value;
      logic                 last;
   } serial_byte_type;

   typedef struct packed {
      logic [31:0]             delta_time;
      logic [ByteWidth-1:0]    status_byte;
      logic [1:0]              data_count;
      logic [ByteWidth-1:0]    data_first;
      logic [ByteWidth-1:0]    data_second;
      logic [3:0]              typed_count;
      logic [MaxBytes*8-1:0]   typed_bytes;
   } event_row_type;

   localparam int unsigned RowCount    = 17;
   localparam int unsigned RandomItems = 480;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ReqWidth-1:0]  req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [ByteWidth-1:0] rsp_tdata;
   logic                 rsp_tlast;

   serial_byte_type pending_bytes[$];
   int unsigned  tx_idle_pct   = 0;
   int unsigned  rx_idle_pct   = 0;
   int unsigned  fail_count    = 0;
   int unsigned  events_sent   = 0;
   int unsigned  bytes_checked = 0;
   int unsigned  long_deltas   = 0;

   midi_event_byte_serializer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void encode_track_event(input event_type ev);
      logic [34:0]          wide;
      logic [ByteWidth-1:0] seq [MaxBytes];
      int                   n_groups;
      int                   n_bytes;
      serial_byte_type      sb;
      wide     = {3'b000, ev.delta_time};
      n_groups = 1;
      while (n_groups < MaxGroups && (wide >> (GroupWidth * n_groups)) != 0) begin
         n_groups++;
      end
      n_bytes = 0;
      for (int g = n_groups - 1; g >= 0; g--) begin
         seq[n_bytes] = {1'b0, wide[GroupWidth*g +: GroupWidth]} | ((g > 0) ? VlqCont : 8'h00);
         n_bytes++;
      end
      seq[n_bytes] = ev.status_byte;
      n_bytes++;
      if (ev.data_count >= 2'd1) begin
         seq[n_bytes] = ev.data_first;
         n_bytes++;
      end
      if (ev.data_count >= 2'd2) begin
         seq[n_bytes] = ev.data_second;
         n_bytes++;
      end
      for (int k = 0; k < n_bytes; k++) begin
         sb.value = seq[k];
         sb.last  = (k == n_bytes - 1);
         pending_bytes.push_back(sb);
      end
   endfunction

   task automatic send_event(input event_type ev, input int unsigned n_typed,
                             input logic [MaxBytes*8-1:0] typed);
      serial_byte_type sb;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, ev.data_second, ev.data_first, ev.data_count,
                     ev.status_byte, ev.delta_time};
      do begin
         @(posedge clock);
      end while (!req_tready);
      if (n_typed == 0) begin
         encode_track_event(ev);
      end else begin
         for (int k = 0; k < n_typed; k++) begin
            sb.value = typed[(n_typed-1-k)*8 +: 8];
            sb.last  = (k == n_typed - 1);
            pending_bytes.push_back(sb);
         end
      end
      events_sent++;
      if (ev.delta_time >= 32'h1000_0000) begin
         long_deltas++;
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      serial_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected byte: out_byte 0x%02h last %0b", rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("out_byte: expected 0x%02h, actual 0x%02h", want.value, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_tlast);
               fail_count++;
            end
            bytes_checked++;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("midi_event_byte_serializer_core_tb NOT OK");
      $finish;
   end

   initial begin
      event_row_type rows [RowCount];
      event_type     ev;
      int unsigned   shape;
      int unsigned   bits;
      int unsigned   drain;
      rows[0]  = '{32'h0000_0000, 8'h90, 2'd2, 8'h3C, 8'h64, 4'd4, 64'h0000_0000_0090_3C64};
      rows[1]  = '{32'h0000_007F, 8'h80, 2'd1, 8'h3C, 8'hAA, 4'd3, 64'h0000_0000_007F_803C};
      rows[2]  = '{32'h0000_0080, 8'hFF, 2'd0, 8'h12, 8'h34, 4'd3, 64'h0000_0000_0081_00FF};
      rows[3]  = '{32'h0000_3FFF, 8'hC0, 2'd1, 8'h05, 8'h00, 4'd4, 64'h0000_0000_FF7F_C005};
      rows[4]  = '{32'h0000_4000, 8'hB0, 2'd2, 8'h07, 8'h7F, 4'd6, 64'h0000_8180_00B0_077F};
      rows[5]  = '{32'h001F_FFFF, 8'hE0, 2'd2, 8'h00, 8'h40, 4'd0, '0};
      rows[6]  = '{32'h0020_0000, 8'hA0, 2'd1, 8'h7F, 8'hFF, 4'd0, '0};
      rows[7]  = '{32'h0FFF_FFFF, 8'hD0, 2'd0, 8'hFF, 8'hFF, 4'd0, '0};
      rows[8]  = '{32'h1000_0000, 8'h00, 2'd2, 8'h00, 8'h00, 4'd8, 64'h8180_8080_0000_0000};
      rows[9]  = '{32'hFFFF_FFFF, 8'hFF, 2'd2, 8'hFF, 8'hFF, 4'd8, 64'h8FFF_FFFF_7FFF_FFFF};
      rows[10] = '{32'h0000_0000, 8'h90, 2'd3, 8'h11, 8'h22, 4'd4, 64'h0000_0000_0090_1122};
      rows[11] = '{32'hFFFF_FFFF, 8'hF0, 2'd3, 8'hA5, 8'h5A, 4'd0, '0};
      rows[12] = '{32'h0000_0005, 8'hF0, 2'd0, 8'hAA, 8'h55, 4'd2, 64'h0000_0000_0000_05F0};
      rows[13] = '{32'hAAAA_AAAA, 8'hAA, 2'd1, 8'h55, 8'hAA, 4'd0, '0};
      rows[14] = '{32'h5555_5555, 8'h55, 2'd2, 8'hAA, 8'h55, 4'd0, '0};
      rows[15] = '{32'h1234_5678, 8'hFF, 2'd3, 8'h01, 8'h80, 4'd0, '0};
      rows[16] = '{32'h8000_0000, 8'h80, 2'd0, 8'h00, 8'h00, 4'd0, '0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < RowCount; i++) begin
         ev.delta_time  = rows[i].delta_time;
         ev.status_byte = rows[i].status_byte;
         ev.data_count  = rows[i].data_count;
         ev.data_first  = rows[i].data_first;
         ev.data_second = rows[i].data_second;
         send_event(ev, rows[i].typed_count, rows[i].typed_bytes);
      end

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 86 : 0;
         rx_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 21 : 0;
         for (int i = 0; i < RandomItems / 3; i++) begin
            shape = $urandom_range(9);
            bits  = GroupWidth * ($urandom_range(MaxGroups - 1) + 1);
            ev.delta_time = $urandom;
            if (bits < 32) begin
               ev.delta_time = ev.delta_time & ((32'd1 << bits) - 1);
               if (shape == 0) begin
                  ev.delta_time = (32'd1 << bits) - 1;
               end else if (shape == 1) begin
                  ev.delta_time = 32'd1 << bits;
               end
            end
            if (shape == 2) begin
               ev.delta_time = 32'd0;
            end
            ev.status_byte = ByteWidth'($urandom_range(255));
            ev.data_count  = 2'($urandom_range(3));
            ev.data_first  = ByteWidth'($urandom_range(255));
            ev.data_second = ByteWidth'($urandom_range(255));
            send_event(ev, 0, '0);
         end
      end
      req_tvalid <= 1'b0;

      drain = 0;
      while (pending_bytes.size() != 0 && drain < 200_000) begin
         @(posedge clock);
         drain++;
      end
      repeat (16) @(posedge clock);

      if (pending_bytes.size() != 0) begin
         $error("%0d expected bytes never arrived", pending_bytes.size());
         fail_count++;
      end
      $display("Sent %0d track events (%0d with five-group deltas), checked %0d bytes,",
               events_sent, long_deltas, bytes_checked);
      $display("under sender-heavy, receiver-heavy and stall-free traffic.");
      if (fail_count == 0) begin
         $display("midi_event_byte_serializer_core_tb OK");
      end else begin
         $display("midi_event_byte_serializer_core_tb NOT OK");
      end
      $finish;
   end

endmodule
